>>> rtl/ptc_pkg.sv
`timescale 1ns / 1ps
package ptc_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = 2;
  localparam int unsigned DivSteps = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_COEF_A = 2'd0,
    REG_COEF_B = 2'd1,
    REG_COEF_C = 2'd2,
    REG_OSS    = 2'd3
  } cfg_reg_t;

  // one raw sample waiting for the back end
  typedef struct packed {
    logic [15:0] ut;
    logic [18:0] up;
  } sample_t;

  // queue status seen by the front end
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // one step of an unsigned restoring divider (32-bit)
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] quo;
    logic [31:0] num;
  } div_st_t;

  function automatic div_st_t div_step(div_st_t s, logic [31:0] den);
    logic [32:0] r;
    div_st_t     o;
    r = {s.rem, s.num[31]};
    o.num = {s.num[30:0], 1'b0};
    if (r >= {1'b0, den}) begin
      o.rem = 32'(r - {1'b0, den});
      o.quo = {s.quo[30:0], 1'b1};
    end else begin
      o.rem = r[31:0];
      o.quo = {s.quo[30:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic [31:0] asr(logic [31:0] x, int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] mul32(logic [31:0] a, logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    return p[31:0];
  endfunction

endpackage

>>> rtl/pressure_temperature_compensation_core.sv
`timescale 1ns / 1ps
// Barometric compensation core. Takes one raw temperature/pressure pair per cycle while
// busy is low (busy rises only if the input queue fills, which does not happen in steady
// state since the back end is fully pipelined). Each item yields one result, shown for one
// cycle with out_valid; the back end holds two 32-stage pipelined dividers. The receiver
// cannot stall. Write configuration only when idle.
module pressure_temperature_compensation_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [15:0]                      in_raw_temperature,
  input  logic [18:0]                      in_raw_pressure,
  output logic                             out_valid,
  output logic signed [15:0]               out_temperature_tenths,
  output logic [17:0]                      out_pressure_pa,
  output logic                             out_divide_error,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ptc_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [63:0]                      cfg_data
);
  import ptc_pkg::*;

  logic [63:0] coef_a_r, coef_b_r;
  logic [31:0] coef_c_r;
  logic [1:0]  oss_r;
  sample_t     s_in, s_out;
  q_stat_t     qs;
  logic        push, pop;

  assign cfg_ready = 1'b1;
  assign busy      = qs.full;
  assign push      = start && !busy;
  assign pop       = !qs.empty;
  assign s_in.ut   = in_raw_temperature;
  assign s_in.up   = in_raw_pressure;

  // store configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r <= '0; coef_b_r <= '0; coef_c_r <= '0; oss_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_COEF_A: coef_a_r <= cfg_data;
        REG_COEF_B: coef_b_r <= cfg_data;
        REG_COEF_C: coef_c_r <= cfg_data[31:0];
        REG_OSS:    oss_r    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  ptc_front u_front (
    .clk, .rst_n, .push, .push_data(s_in), .pop, .pop_data(s_out), .stat(qs)
  );

  ptc_back u_back (
    .clk, .rst_n, .in_v(pop), .in_s(s_out),
    .coef_a(coef_a_r), .coef_b(coef_b_r), .coef_c(coef_c_r), .oss(oss_r),
    .out_v(out_valid), .out_t(out_temperature_tenths), .out_p(out_pressure_pa),
    .out_err(out_divide_error)
  );
endmodule

>>> rtl/ptc_front.sv
`timescale 1ns / 1ps
// Accepts samples into a short queue.
module ptc_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ptc_pkg::sample_t push_data,
  input  logic             pop,
  output ptc_pkg::sample_t pop_data,
  output ptc_pkg::q_stat_t stat
);
  import ptc_pkg::*;

  sample_t          mem_r [QDepth];
  logic [QPtrW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QPtrW:0]   cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == (QPtrW+1)'(QDepth));
  assign stat.empty = (cnt_r == '0);
  assign pop_data   = mem_r[rp_r];

  // advance pointers
  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end

  // hold item data
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end
endmodule

>>> rtl/ptc_back.sv
`timescale 1ns / 1ps
// Pipelined compensation: temperature math, two 32-stage dividers, pressure math.
module ptc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_v,
  input  ptc_pkg::sample_t   in_s,
  input  logic [63:0]        coef_a,
  input  logic [63:0]        coef_b,
  input  logic [31:0]        coef_c,
  input  logic [1:0]         oss,
  output logic               out_v,
  output logic signed [15:0] out_t,
  output logic [17:0]        out_p,
  output logic               out_err
);
  import ptc_pkg::*;

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = 32'($signed(coef_a[15:0]));
  assign ac2 = 32'($signed(coef_a[31:16]));
  assign ac3 = 32'($signed(coef_a[47:32]));
  assign ac4 = {16'd0, coef_a[63:48]};
  assign ac5 = {16'd0, coef_b[15:0]};
  assign ac6 = {16'd0, coef_b[31:16]};
  assign b1  = 32'($signed(coef_b[47:32]));
  assign b2  = 32'($signed(coef_b[63:48]));
  assign mc  = 32'($signed(coef_c[15:0]));
  assign md  = 32'($signed(coef_c[31:16]));

  // stage A: x1 product
  logic        a_v_r;
  logic [31:0] a_prod_r;
  logic [18:0] a_up_r;
  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0; else a_v_r <= in_v;
    a_prod_r <= mul32({16'd0, in_s.ut} - ac6, ac5);
    a_up_r   <= in_s.up;
  end

  // stage B: set up temperature division
  logic [31:0] b_x1, b_d, b_num;
  assign b_x1  = asr(a_prod_r, 15);
  assign b_d   = b_x1 + md;
  assign b_num = mc << 11;

  // divider 1 pipeline
  div_st_t     d1_r   [DivSteps+1];
  logic [31:0] d1_den_r [DivSteps+1];
  logic        d1_v_r [DivSteps+1];
  logic        d1_neg_r [DivSteps+1];
  logic        d1_err_r [DivSteps+1];
  logic [31:0] d1_x1_r [DivSteps+1];
  logic [18:0] d1_up_r [DivSteps+1];

  always_ff @(posedge clk) begin
    if (!rst_n) d1_v_r[0] <= 1'b0; else d1_v_r[0] <= a_v_r;
    d1_r[0].rem <= '0;
    d1_r[0].quo <= '0;
    d1_r[0].num <= b_num[31] ? 32'(0) - b_num : b_num;
    d1_den_r[0] <= b_d[31] ? 32'(0) - b_d : b_d;
    d1_neg_r[0] <= b_num[31] ^ b_d[31];
    d1_err_r[0] <= (b_d == '0);
    d1_x1_r[0]  <= b_x1;
    d1_up_r[0]  <= a_up_r;
  end

  for (genvar i = 0; i < DivSteps; i++) begin : g_d1
    always_ff @(posedge clk) begin
      if (!rst_n) d1_v_r[i+1] <= 1'b0; else d1_v_r[i+1] <= d1_v_r[i];
      d1_r[i+1]     <= div_step(d1_r[i], d1_den_r[i]);
      d1_den_r[i+1] <= d1_den_r[i];
      d1_neg_r[i+1] <= d1_neg_r[i];
      d1_err_r[i+1] <= d1_err_r[i];
      d1_x1_r[i+1]  <= d1_x1_r[i];
      d1_up_r[i+1]  <= d1_up_r[i];
    end
  end

  // stage C: b5, b6
  logic [31:0] c_x2, c_b5;
  assign c_x2 = d1_neg_r[DivSteps] ? 32'(0) - d1_r[DivSteps].quo : d1_r[DivSteps].quo;
  assign c_b5 = d1_x1_r[DivSteps] + c_x2;

  logic        c_v_r, c_err_r;
  logic [31:0] c_b5_r, c_b6_r, c_sq_r;
  logic [18:0] c_up_r;
  always_ff @(posedge clk) begin
    if (!rst_n) c_v_r <= 1'b0; else c_v_r <= d1_v_r[DivSteps];
    c_err_r <= d1_err_r[DivSteps];
    c_b5_r  <= c_b5;
    c_b6_r  <= c_b5 - 32'd4000;
    c_sq_r  <= asr(mul32(c_b5 - 32'd4000, c_b5 - 32'd4000), 12);
    c_up_r  <= d1_up_r[DivSteps];
  end

  // stage D: four coefficient products
  logic        e_v_r, e_err_r;
  logic [31:0] e_b5_r, e_m1_r, e_m2_r, e_m3_r, e_m4_r;
  logic [18:0] e_up_r;
  always_ff @(posedge clk) begin
    if (!rst_n) e_v_r <= 1'b0; else e_v_r <= c_v_r;
    e_err_r <= c_err_r;
    e_b5_r  <= c_b5_r;
    e_m1_r  <= mul32(b2, c_sq_r);
    e_m2_r  <= mul32(ac2, c_b6_r);
    e_m3_r  <= mul32(ac3, c_b6_r);
    e_m4_r  <= mul32(b1, c_sq_r);
    e_up_r  <= c_up_r;
  end

  // stage E: b3, x3
  logic [31:0] f_x3a, f_sh, f_sum, f_mag, f_b3, f_x3;
  assign f_x3a = asr(e_m1_r, 11) + asr(e_m2_r, 11);
  assign f_sh  = ((ac1 << 2) + f_x3a) << oss;
  // signed /4 truncating: divide the magnitude, then restore the sign
  assign f_sum = f_sh + 32'd2;
  assign f_mag = f_sum[31] ? 32'(0) - f_sum : f_sum;
  assign f_b3  = f_sum[31] ? 32'(0) - (f_mag >> 2) : f_mag >> 2;
  assign f_x3  = asr(asr(e_m3_r, 13) + asr(e_m4_r, 16) + 32'd2, 2);

  logic        f_v_r, f_err_r;
  logic [31:0] f_b5_r, f_b4p_r, f_diff_r;
  always_ff @(posedge clk) begin
    if (!rst_n) f_v_r <= 1'b0; else f_v_r <= e_v_r;
    f_err_r  <= e_err_r;
    f_b5_r   <= e_b5_r;
    f_b4p_r  <= mul32(ac4, f_x3 + 32'd32768);
    f_diff_r <= {13'd0, e_up_r} - f_b3;
  end

  // stage F: b7
  logic [31:0] g_b4;
  assign g_b4 = f_b4p_r >> 15;
  logic        g_v_r, g_err_r;
  logic [31:0] g_b5_r, g_b4_r, g_b7_r;
  always_ff @(posedge clk) begin
    if (!rst_n) g_v_r <= 1'b0; else g_v_r <= f_v_r;
    g_err_r <= f_err_r | (g_b4 == '0);
    g_b5_r  <= f_b5_r;
    g_b4_r  <= g_b4;
    g_b7_r  <= mul32(f_diff_r, 32'd50000 >> oss);
  end

  // divider 2 pipeline (unsigned)
  div_st_t     d2_r   [DivSteps+1];
  logic [31:0] d2_den_r [DivSteps+1];
  logic        d2_v_r [DivSteps+1];
  logic        d2_hi_r [DivSteps+1];
  logic        d2_err_r [DivSteps+1];
  logic [31:0] d2_b5_r [DivSteps+1];

  always_ff @(posedge clk) begin
    if (!rst_n) d2_v_r[0] <= 1'b0; else d2_v_r[0] <= g_v_r;
    d2_r[0].rem <= '0;
    d2_r[0].quo <= '0;
    d2_r[0].num <= g_b7_r[31] ? g_b7_r : g_b7_r << 1;
    d2_den_r[0] <= g_b4_r;
    d2_hi_r[0]  <= g_b7_r[31];
    d2_err_r[0] <= g_err_r;
    d2_b5_r[0]  <= g_b5_r;
  end

  for (genvar i = 0; i < DivSteps; i++) begin : g_d2
    always_ff @(posedge clk) begin
      if (!rst_n) d2_v_r[i+1] <= 1'b0; else d2_v_r[i+1] <= d2_v_r[i];
      d2_r[i+1]     <= div_step(d2_r[i], d2_den_r[i]);
      d2_den_r[i+1] <= d2_den_r[i];
      d2_hi_r[i+1]  <= d2_hi_r[i];
      d2_err_r[i+1] <= d2_err_r[i];
      d2_b5_r[i+1]  <= d2_b5_r[i];
    end
  end

  // stage H: p and the square of p >>> 8
  logic [31:0] h_p, h_pp;
  assign h_p  = d2_hi_r[DivSteps] ? d2_r[DivSteps].quo << 1 : d2_r[DivSteps].quo;
  assign h_pp = asr(h_p, 8);
  logic        h_v_r, h_err_r;
  logic [31:0] h_p_r, h_sq_r, h_m2_r, h_b5_r;
  always_ff @(posedge clk) begin
    if (!rst_n) h_v_r <= 1'b0; else h_v_r <= d2_v_r[DivSteps];
    h_err_r <= d2_err_r[DivSteps];
    h_p_r   <= h_p;
    h_sq_r  <= mul32(h_pp, h_pp);
    h_m2_r  <= mul32(32'(0) - 32'd7357, h_p);
    h_b5_r  <= d2_b5_r[DivSteps];
  end

  logic        i_v_r, i_err_r;
  logic [31:0] i_p_r, i_m1_r, i_m2_r, i_b5_r;
  always_ff @(posedge clk) begin
    if (!rst_n) i_v_r <= 1'b0; else i_v_r <= h_v_r;
    i_err_r <= h_err_r;
    i_p_r   <= h_p_r;
    i_m1_r  <= mul32(h_sq_r, 32'd3038);
    i_m2_r  <= h_m2_r;
    i_b5_r  <= h_b5_r;
  end

  // final: sum and saturate
  logic [31:0] j_pr, j_t;
  logic signed [15:0] j_ts;
  logic [17:0] j_ps;
  always_comb begin
    j_pr = i_p_r + asr(asr(i_m1_r, 16) + asr(i_m2_r, 16) + 32'd3791, 4);
    j_t  = asr(i_b5_r + 32'd8, 4);
    if ($signed(j_t) > 32'sd32767) j_ts = 16'sh7fff;
    else if ($signed(j_t) < -32'sd32768) j_ts = 16'sh8000;
    else j_ts = j_t[15:0];
    if (j_pr[31]) j_ps = '0;
    else if (j_pr > 32'd262143) j_ps = 18'h3ffff;
    else j_ps = j_pr[17:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_v <= 1'b0; else out_v <= i_v_r;
    out_err <= i_err_r;
    out_t   <= i_err_r ? 16'sd0 : j_ts;
    out_p   <= i_err_r ? 18'd0 : j_ps;
  end
endmodule

>>> rtl/ptc_checker.sv
`timescale 1ns / 1ps
module ptc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               busy,
  input logic               out_valid,
  input logic signed [15:0] out_temperature_tenths,
  input logic [17:0]        out_pressure_pa,
  input logic               out_divide_error,
  input logic               cfg_ready
);
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_error |-> out_temperature_tenths == 16'sd0
                                     && out_pressure_pa == 18'd0)
    else $error("error result not zero");
  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("queue filled");
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("cfg not ready");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");
endmodule

bind pressure_temperature_compensation_core ptc_checker u_chk (.*);
